// File: sv/display_line_timing_status_macros.svh
// Assertion macros for the display line timing and status block.
// Included by the modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef DISPLAY_LINE_TIMING_STATUS_MACROS_SVH
`define DISPLAY_LINE_TIMING_STATUS_MACROS_SVH

// Check that a condition implies another in the same cycle
`define DLTS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle
`define DLTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/dlts_pkg.sv
// Shared types and constants for the display line timing and status block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package dlts_pkg;

  // Event and access codes
  typedef enum logic [1:0] {
    OP_HBLANK   = 2'd0,
    OP_LINE_END = 2'd1,
    OP_WRITE    = 2'd2,
    OP_READ     = 2'd3
  } op_t;

  // Line timing for both modes
  localparam logic [8:0] DS_LINES       = 9'd263;
  localparam logic [8:0] DS_VBLANK_END  = 9'd262;
  localparam logic [8:0] DS_VISIBLE     = 9'd192;
  localparam logic [8:0] GBA_LINES      = 9'd228;
  localparam logic [8:0] GBA_VBLANK_END = 9'd227;
  localparam logic [8:0] GBA_VISIBLE    = 9'd160;
  localparam logic [8:0] LINE_MAX       = 9'd262;

  // Status word layout
  localparam logic [15:0] WRITABLE_BITS = 16'hFFB8;
  localparam int BIT_F_VBLANK = 0;
  localparam int BIT_F_HBLANK = 1;
  localparam int BIT_F_MATCH  = 2;
  localparam int BIT_E_VBLANK = 3;
  localparam int BIT_E_HBLANK = 4;
  localparam int BIT_E_MATCH  = 5;
  localparam int BIT_CMP_HIGH = 7;

  typedef struct packed {
    op_t         operation;
    logic        cpu_select;
    logic [15:0] write_mask;
    logic [15:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] status_read;
    logic [8:0]  line_count;
    logic [2:0]  irq_cpu0;
    logic [2:0]  irq_cpu1;
    logic [1:0]  dma_vblank;
    logic [1:0]  dma_hblank;
    logic        frame_end;
    logic        frame_start;
  } out_item_t;

  // Architectural state: one status word per CPU and the line counter
  typedef struct packed {
    logic [1:0][15:0] status;
    logic [8:0]       line;
  } dlts_state_t;

endpackage

`default_nettype wire

// File: sv/dlts_step.sv
// Combinational update for one event or status access.
// Depends on dlts_pkg; computes next state and the result item.
`timescale 1ns / 1ps
`default_nettype none

module dlts_step
  import dlts_pkg::*;
(
  input  in_item_t    item,
  input  dlts_state_t cur,
  input  logic        gba_mode,
  output dlts_state_t nxt,
  output out_item_t   res
);

  always_comb begin
    dlts_state_t st;
    out_item_t   r;
    logic [8:0]  lc;
    logic [8:0]  tgt;
    logic [15:0] msk;
    st  = cur;
    r   = '0;
    lc  = cur.line;
    tgt = '0;
    msk = item.write_mask & WRITABLE_BITS;
    unique case (item.operation)
      OP_HBLANK: begin
        if (gba_mode) begin
          if (cur.line < GBA_VISIBLE) r.dma_hblank = 2'b10;
          st.status[1][BIT_F_HBLANK] = 1'b1;
          if (st.status[1][BIT_E_HBLANK]) r.irq_cpu1[1] = 1'b1;
        end else begin
          if (cur.line < DS_VISIBLE) r.dma_hblank = 2'b01;
          st.status[0][BIT_F_HBLANK] = 1'b1;
          st.status[1][BIT_F_HBLANK] = 1'b1;
          if (st.status[0][BIT_E_HBLANK]) r.irq_cpu0[1] = 1'b1;
          if (st.status[1][BIT_E_HBLANK]) r.irq_cpu1[1] = 1'b1;
        end
      end
      OP_LINE_END: begin
        lc = cur.line + 9'd1;
        if (gba_mode) begin
          st.status[1][BIT_F_HBLANK] = 1'b0;
          // advance line, enter or leave vblank, wrap past the frame
          if (lc == GBA_VISIBLE) begin
            st.status[1][BIT_F_VBLANK] = 1'b1;
            if (st.status[1][BIT_E_VBLANK]) r.irq_cpu1[0] = 1'b1;
            r.dma_vblank = 2'b10;
            r.frame_end  = 1'b1;
          end else if (lc == GBA_VBLANK_END) begin
            st.status[1][BIT_F_VBLANK] = 1'b0;
          end else if (lc >= GBA_LINES || lc == 9'd0) begin
            lc = 9'd0;
            r.frame_start = 1'b1;
          end
          // 8-bit compare line
          tgt = {1'b0, st.status[1][15:8]};
          st.status[1][BIT_F_MATCH] = (lc == tgt);
          if (lc == tgt && st.status[1][BIT_E_MATCH]) r.irq_cpu1[2] = 1'b1;
        end else begin
          if (lc == DS_VISIBLE) begin
            st.status[0][BIT_F_VBLANK] = 1'b1;
            st.status[1][BIT_F_VBLANK] = 1'b1;
            if (st.status[0][BIT_E_VBLANK]) r.irq_cpu0[0] = 1'b1;
            if (st.status[1][BIT_E_VBLANK]) r.irq_cpu1[0] = 1'b1;
            r.dma_vblank = 2'b11;
            r.frame_end  = 1'b1;
          end else if (lc == DS_VBLANK_END) begin
            st.status[0][BIT_F_VBLANK] = 1'b0;
            st.status[1][BIT_F_VBLANK] = 1'b0;
          end else if (lc >= DS_LINES || lc == 9'd0) begin
            lc = 9'd0;
            r.frame_start = 1'b1;
          end
          // 9-bit compare line per CPU, then drop hblank
          for (int i = 0; i < 2; i++) begin
            tgt = {st.status[i][BIT_CMP_HIGH], st.status[i][15:8]};
            st.status[i][BIT_F_MATCH] = (lc == tgt);
            st.status[i][BIT_F_HBLANK] = 1'b0;
          end
          if (st.status[0][BIT_F_MATCH] && st.status[0][BIT_E_MATCH]) r.irq_cpu0[2] = 1'b1;
          if (st.status[1][BIT_F_MATCH] && st.status[1][BIT_E_MATCH]) r.irq_cpu1[2] = 1'b1;
        end
        st.line = lc;
      end
      OP_WRITE: begin
        st.status[item.cpu_select] = (cur.status[item.cpu_select] & ~msk) |
                                     (item.write_value & msk);
      end
      OP_READ: begin
        st = cur;
      end
      default: begin
        st = cur;
      end
    endcase
    r.status_read = st.status[item.cpu_select];
    r.line_count  = st.line;
    nxt = st;
    res = r;
  end

endmodule

`default_nettype wire

// File: sv/dlts_out_stage.sv
// Result register with valid/stall handshake for the timing block.
// Depends on dlts_pkg; tells the upstream stage when it may advance.
`timescale 1ns / 1ps
`default_nettype none

module dlts_out_stage
  import dlts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load_valid,
  input  out_item_t load_item,
  output logic      advance,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic      valid_r;
  out_item_t item_r;

  // Advance when the register is empty or its transfer completes now
  assign advance   = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  // Hold valid across a stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= load_valid;
    end
  end

  // Hold payload across a stall
  always_ff @(posedge clk) begin
    if (advance && load_valid) begin
      item_r <= load_item;
    end
  end

endmodule

`default_nettype wire

// File: sv/display_line_timing_status.sv
// Top level of the display line timing and status block.
// Depends on dlts_pkg, dlts_step, dlts_out_stage and the assertion macro header.
//
// Usage:
//   Input channel (in_valid / in_stall / in_item) carries one event or status
//   access per transfer: hblank start, line end, masked status write, status
//   read. Each accepted item yields exactly one result transfer on the output
//   channel (out_valid / out_stall / out_item) with the addressed status word,
//   the line counter and the interrupt, DMA and frame pulses it caused.
//   cfg_we / cfg_wdata write the gba_mode bit; write it only while no item is
//   in flight.
//   An accepted item passes through the input register, then the result
//   register, before out_valid rises for it. Throughput: one item per cycle
//   while the receiver does not stall.
//   When the receiver stalls, the result register holds; one more item may
//   enter the input register, after which in_stall rises until the stall ends.
//   Reset (rst_n low, synchronous) clears both status words, the line counter,
//   gba_mode and both valid flags.
`timescale 1ns / 1ps
`default_nettype none

`include "display_line_timing_status_macros.svh"

module display_line_timing_status
  import dlts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  logic        gba_mode_r;
  logic        s1_valid_r;
  in_item_t    s1_item_r;
  dlts_state_t state_r;
  dlts_state_t state_nxt;
  out_item_t   res;
  logic        advance;

  // Stall only when the input register is full and cannot move on
  assign in_stall = s1_valid_r && !advance;

  // Mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gba_mode_r <= 1'b0;
    end else if (cfg_we) begin
      gba_mode_r <= cfg_wdata;
    end
  end

  // Input register: load on every transfer, drop when drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item_r <= in_item;
    end
  end

  // Commit state when the item moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_valid_r && advance) begin
      state_r <= state_nxt;
    end
  end

  dlts_step u_step (
    .item     (s1_item_r),
    .cur      (state_r),
    .gba_mode (gba_mode_r),
    .nxt      (state_nxt),
    .res      (res)
  );

  dlts_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (s1_valid_r),
    .load_item  (res),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

  `DLTS_ASSERT_SAME(a_line_range, 1'b1, state_r.line <= LINE_MAX, "line counter out of range")
  `DLTS_ASSERT_SAME(a_hold_input, s1_valid_r && out_valid && out_stall, in_stall,
                    "input not held during output stall")
  `DLTS_ASSERT_NEXT(a_result_follows, s1_valid_r && advance, out_valid,
                    "result lost after input stage")
  `DLTS_ASSERT_SAME(a_frame_pulses, out_valid,
                    !(out_item.frame_end && out_item.frame_start), "frame start and end together")
  `DLTS_ASSERT_SAME(a_gba_cpu0_quiet, s1_valid_r && gba_mode_r, res.irq_cpu0 == 3'd0,
                    "CPU 0 interrupt in single-CPU mode")

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for display_line_timing_status: random hblank, line-end and
// status-access transfers with idling on both channels, each result checked field by field.
// Depends on dlts_pkg and the display_line_timing_status RTL.

module testbench;
  import dlts_pkg::*;

  localparam int unsigned HOLD_OFF_CYCLES = 60;
  localparam int unsigned STALL_LIMIT     = 1000;
  localparam int unsigned PIPE_LATENCY    = 2;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam logic [15:0] ENABLE_ALL      = (16'h1 << BIT_E_VBLANK) | (16'h1 << BIT_E_HBLANK) |
                                            (16'h1 << BIT_E_MATCH);

  // Tracks line timing and both status words, and holds the results still owed by the block
  class line_timing_scoreboard;
    logic [15:0] status_word [2];
    logic [8:0]  line;
    bit          gba;
    out_item_t   expected_q [$];
    int unsigned errors;

    function new();
      status_word[0] = '0;
      status_word[1] = '0;
      line = '0;
      gba = 1'b0;
      errors = 0;
    endfunction

    function void set_mode(bit m);
      gba = m;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Update one CPU's line-match flag; return its interrupt request
    function bit match_line(int c, logic [8:0] target);
      if (line == target) begin
        status_word[c][BIT_F_MATCH] = 1'b1;
        return status_word[c][BIT_E_MATCH];
      end
      status_word[c][BIT_F_MATCH] = 1'b0;
      return 1'b0;
    endfunction

    // Advance the timing state by one accepted transfer and queue its result
    function void note_item(in_item_t it);
      out_item_t   r;
      logic [2:0]  irq [2];
      logic [15:0] lanes;
      logic [8:0]  first_vblank;
      logic [8:0]  last_vblank;
      logic [8:0]  frame_lines;
      int          first;
      r = '0;
      irq[0] = '0;
      irq[1] = '0;
      first = gba ? 1 : 0;
      first_vblank = gba ? GBA_VISIBLE : DS_VISIBLE;
      last_vblank = gba ? GBA_VBLANK_END : DS_VBLANK_END;
      frame_lines = gba ? GBA_LINES : DS_LINES;
      case (it.operation)
        OP_HBLANK: begin
          if (line < first_vblank) r.dma_hblank = gba ? 2'b10 : 2'b01;
          for (int c = first; c < 2; c++) begin
            status_word[c][BIT_F_HBLANK] = 1'b1;
            irq[c][1] = status_word[c][BIT_E_HBLANK];
          end
        end
        OP_LINE_END: begin
          line = line + 9'd1;
          if (line == first_vblank) begin
            for (int c = first; c < 2; c++) begin
              status_word[c][BIT_F_VBLANK] = 1'b1;
              irq[c][0] = status_word[c][BIT_E_VBLANK];
            end
            r.dma_vblank = gba ? 2'b10 : 2'b11;
            r.frame_end = 1'b1;
          end else if (line == last_vblank) begin
            for (int c = first; c < 2; c++) status_word[c][BIT_F_VBLANK] = 1'b0;
          end else if (line >= frame_lines || line == 9'd0) begin
            // wrap, also when a mode change left the counter past the frame
            line = '0;
            r.frame_start = 1'b1;
          end
          // gba timing compares 8 bits; handheld takes bit 7 as line bit 8
          for (int c = first; c < 2; c++) begin
            if (gba) irq[c][2] = match_line(c, {1'b0, status_word[c][15:8]});
            else irq[c][2] = match_line(c, {status_word[c][BIT_CMP_HIGH], status_word[c][15:8]});
            status_word[c][BIT_F_HBLANK] = 1'b0;
          end
        end
        OP_WRITE: begin
          lanes = it.write_mask & WRITABLE_BITS;
          status_word[it.cpu_select] = (status_word[it.cpu_select] & ~lanes) |
                                       (it.write_value & lanes);
        end
        default: ;
      endcase
      r.status_read = status_word[it.cpu_select];
      r.line_count = line;
      r.irq_cpu0 = irq[0];
      r.irq_cpu1 = irq[1];
      expected_q.push_back(r);
    endfunction

    function void check_field(string name, logic [15:0] exp, logic [15:0] act);
      if (act !== exp) begin
        $error("%s mismatch: expected %0h, actual %0h", name, exp, act);
        errors++;
      end
    endfunction

    // Compare a result transfer with the oldest queued result
    function void check_result(out_item_t got);
      out_item_t exp;
      if (expected_q.size() == 0) begin
        $error("result transfer with no result pending: %0h", got);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      check_field("status_read", exp.status_read, got.status_read);
      check_field("line_count", 16'(exp.line_count), 16'(got.line_count));
      check_field("irq_cpu0", 16'(exp.irq_cpu0), 16'(got.irq_cpu0));
      check_field("irq_cpu1", 16'(exp.irq_cpu1), 16'(got.irq_cpu1));
      check_field("dma_vblank", 16'(exp.dma_vblank), 16'(got.dma_vblank));
      check_field("dma_hblank", 16'(exp.dma_hblank), 16'(got.dma_hblank));
      check_field("frame_end", 16'(exp.frame_end), 16'(got.frame_end));
      check_field("frame_start", 16'(exp.frame_start), 16'(got.frame_start));
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b0;

  line_timing_scoreboard sb = new();

  bit          quiet_tail = 1'b0;
  bit          hold_off_req = 1'b0;
  int unsigned sender_calm = 0;
  int unsigned receiver_calm = 0;
  int unsigned idle_cycles = 0;

  display_line_timing_status dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Status word bits that select a compare line in the given timing
  function automatic logic [15:0] compare_bits(logic [8:0] target, bit gba_timing);
    return {target[7:0], target[8] & ~gba_timing, 7'b0};
  endfunction

  function automatic in_item_t make_item(op_t op, logic cpu, logic [15:0] mask,
                                         logic [15:0] value);
    in_item_t it;
    it.operation = op;
    it.cpu_select = cpu;
    it.write_mask = mask;
    it.write_value = value;
    return it;
  endfunction

  // Event with random filler in the fields it ignores
  function automatic in_item_t random_event(op_t op);
    return make_item(op, 1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom));
  endfunction

  // Offer one item and hold it until the transfer
  task automatic send_item(in_item_t it);
    in_item <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic pause_input(int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stop offering until every queued result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_mode(bit m);
    wait_drained();
    repeat (PIPE_LATENCY) @(posedge clk);
    cfg_wdata <= m;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_mode(m);
  endtask

  // Random sender gaps, with calm stretches and none in the tail
  task automatic maybe_idle_input();
    if (quiet_tail) return;
    if (sender_calm > 0) begin
      sender_calm--;
      return;
    end
    case ($urandom_range(0, 15))
      0: sender_calm = $urandom_range(20, 60);
      1, 2, 3: pause_input($urandom_range(1, 11));
      default: ;
    endcase
  endtask

  // Masked write or read; writes often aim the compare line just ahead
  task automatic send_access();
    in_item_t   it;
    logic [8:0] target;
    it = random_event(($urandom_range(0, 2) == 0) ? OP_READ : OP_WRITE);
    case ($urandom_range(0, 4))
      0: it.write_mask = 16'h00FF;
      1: it.write_mask = 16'hFF00;
      2: it.write_mask = 16'hFFFF;
      default: ;
    endcase
    if ($urandom_range(0, 1) == 1) begin
      target = sb.line + 9'($urandom_range(0, 3));
      it.write_value = (it.write_value & 16'h007F) | compare_bits(target, sb.gba);
    end
    send_item(it);
  endtask

  // Run display lines: hblank, accesses, line end, with some broken sequences
  task automatic run_lines(int unsigned n);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: ;
        1: begin
          maybe_idle_input();
          send_item(random_event(OP_HBLANK));
          send_item(random_event(OP_HBLANK));
        end
        default: begin
          maybe_idle_input();
          send_item(random_event(OP_HBLANK));
        end
      endcase
      while ($urandom_range(0, 2) == 0) begin
        maybe_idle_input();
        send_access();
      end
      maybe_idle_input();
      send_item(random_event(OP_LINE_END));
    end
  endtask

  // Check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  // Receiver: random stall bursts, calm stretches, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet_tail) begin
        if (receiver_calm > 0) begin
          receiver_calm--;
        end else begin
          case ($urandom_range(0, 15))
            0: receiver_calm = $urandom_range(20, 60);
            1, 2, 3: begin
              out_stall <= 1'b1;
              repeat ($urandom_range(1, 11)) @(posedge clk);
              out_stall <= 1'b0;
            end
            default: ;
          endcase
        end
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  initial begin
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values, read-only bits, empty mask
    send_item(make_item(OP_READ, 1'b0, 16'h0000, 16'hFFFF));
    send_item(make_item(OP_READ, 1'b1, 16'hFFFF, 16'h0000));
    send_item(make_item(OP_WRITE, 1'b0, 16'hFFFF, 16'hFFFF));
    send_item(make_item(OP_WRITE, 1'b0, 16'h0000, 16'h0000));
    send_item(make_item(OP_WRITE, 1'b1, 16'hFFFF, 16'h0000));

    // Handheld timing: compare line 1 on CPU 0, line 256 on CPU 1, all enables
    send_item(make_item(OP_WRITE, 1'b0, 16'hFFFF, compare_bits(9'd1, 1'b0) | ENABLE_ALL));
    send_item(make_item(OP_WRITE, 1'b1, 16'hFFFF, compare_bits(9'd256, 1'b0) | ENABLE_ALL));
    send_item(make_item(OP_HBLANK, 1'b0, 16'h0000, 16'h0000));
    send_item(make_item(OP_LINE_END, 1'b1, 16'hFFFF, 16'hFFFF));
    send_item(make_item(OP_HBLANK, 1'b1, 16'hFFFF, 16'hFFFF));
    send_item(make_item(OP_LINE_END, 1'b0, 16'h0000, 16'h0000));
    send_item(make_item(OP_READ, 1'b1, 16'h0000, 16'h0000));

    // Single-CPU timing: events leave CPU 0 alone, its word stays writable
    write_mode(1'b1);
    send_item(make_item(OP_WRITE, 1'b1, 16'hFFFF, compare_bits(9'd4, 1'b1) | ENABLE_ALL));
    send_item(make_item(OP_HBLANK, 1'b0, 16'h0000, 16'h0000));
    send_item(make_item(OP_LINE_END, 1'b0, 16'h0000, 16'h0000));
    send_item(make_item(OP_LINE_END, 1'b1, 16'h0000, 16'h0000));
    send_item(make_item(OP_WRITE, 1'b0, 16'hFFFF, 16'hFFFF));
    send_item(make_item(OP_HBLANK, 1'b0, 16'h0000, 16'h0000));
    send_item(make_item(OP_READ, 1'b0, 16'h0000, 16'h0000));

    // Full frames in each timing
    write_mode(1'b0);
    run_lines(300);
    write_mode(1'b1);
    run_lines(260);

    // Park the counter past the short frame, then switch to force a wrap
    write_mode(1'b0);
    while (sb.line != 9'd240) begin
      maybe_idle_input();
      send_item(random_event(OP_LINE_END));
    end
    write_mode(1'b1);
    run_lines(20);

    // Fill the block against a long receiver hold-off, then drain it
    write_mode(1'b0);
    hold_off_req = 1'b1;
    for (int i = 0; i < 24; i++)
      send_item(random_event(i[0] ? OP_LINE_END : OP_HBLANK));
    wait_drained();
    run_lines(40);

    // Tail without idling
    write_mode(1'b1);
    quiet_tail = 1'b1;
    run_lines(40);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
